// File: src/sida_pkg.sv
package sida_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int CHAR_W = 8;
   localparam int DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;

   localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

   // decimal digits needed for any W-bit unsigned magnitude (1233/4096 ~ log10 2)
   function automatic int digit_count(input int w);
      return (w * 1233) / 4096 + 1;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_DIGIT,
      ST_TERM
   } state_type;

   typedef struct packed {
      logic start;
      logic pop;
   } conv_ctl_type;

   typedef struct packed {
      logic done;
      logic [DIGIT_W-1:0] top_digit;
   } conv_stat_type;

endpackage

// File: src/signed_int_to_decimal_ascii_unit.sv
// Sequence: the value is converted one bit per cycle through a shared shift-add-3
//   unit, then the sign (if negative), each of the ND digit slots in turn (emitted or
//   skipped) and the terminator are loaded into the output register, which can stall.
// A new value is taken only in idle, once the last one's terminator has loaded.
// Reset: synchronous, active high; clears the sequencer and output valid.
module signed_int_to_decimal_ascii_unit #(
   parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [7:0]                    req_terminator,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_char_out,
   output logic                          rsp_last
);
   import sida_pkg::*;

   localparam int ND = digit_count(VALUE_WIDTH);
   localparam int IDX_W = $clog2(ND);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ND - 1);

   state_type state_ff, state_in;

   logic               neg_ff, neg_in;
   logic [CHAR_W-1:0]  term_ff, term_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               started_ff, started_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               req_take;
   logic               out_free;
   logic               digit_last;
   logic               digit_emit;
   logic [VALUE_WIDTH-1:0] mag;

   conv_ctl_type  conv_ctl;
   conv_stat_type conv_stat;

   // Magnitude in VALUE_WIDTH unsigned bits; the most negative value negates
   // to 2^(VALUE_WIDTH-1), which still fits, so it prints its true magnitude.
   assign mag = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;

   // Output register frees when empty or when its transfer completes now.
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // Leading zeros are skipped; the lowest digit always prints (zero -> "0").
   assign digit_last = (idx_ff == IDX_LAST);
   assign digit_emit = started_ff | (conv_stat.top_digit != '0) | digit_last;

   sida_conv #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_conv (
      .clock(clock),
      .reset(reset),
      .ctl  (conv_ctl),
      .mag  (mag),
      .stat (conv_stat)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (digit_emit && out_free && digit_last) begin
               state_in = ST_TERM;
            end
         end
         ST_TERM: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output register control
   always_comb begin
      neg_in        = neg_ff;
      term_in       = term_ff;
      idx_in        = idx_ff;
      started_in    = started_ff;
      conv_ctl      = '0;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in         = req_value[VALUE_WIDTH-1];
               term_in        = req_terminator;
               conv_ctl.start = 1'b1;
            end
         end
         ST_CONV: begin
            idx_in     = '0;
            started_in = 1'b0;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         ST_DIGIT: begin
            if (!digit_emit) begin
               conv_ctl.pop = 1'b1;
               idx_in       = idx_ff + 1'b1;
            end else if (out_free) begin
               conv_ctl.pop = 1'b1;
               idx_in       = digit_last ? idx_ff : idx_ff + 1'b1;
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, conv_stat.top_digit};
               rsp_last_in  = 1'b0;
            end
         end
         ST_TERM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = term_ff;
               rsp_last_in  = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         started_ff   <= started_in;
      end
      neg_ff      <= neg_in;
      term_ff     <= term_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   // converter runs only while the sequencer waits on it
   a_conv_only_in_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CONV) |-> conv_stat.done)
      else $error("converter busy outside conversion");

   // an accepted value always starts a conversion
   a_take_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_CONV) && !conv_stat.done)
      else $error("accepted value did not start conversion");

   // digit index stays within the BCD register
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_LAST)
      else $error("digit index out of range");

   // a non-final character from the digit phase is a decimal digit
   a_digit_char: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_DIGIT) && rsp_valid_ff && !rsp_last_ff
         && ($past(rsp_valid_in) && !($past(rsp_valid_ff) && $past(rsp_stall)))
      |-> (rsp_char_ff >= CH_ZERO) && (rsp_char_ff <= CH_ZERO + 8'd9))
      else $error("bad digit character");

endmodule

// File: src/sida_conv.sv
module sida_conv #(
   parameter int VALUE_WIDTH = sida_pkg::VALUE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sida_pkg::conv_ctl_type    ctl,
   input  logic [VALUE_WIDTH-1:0]    mag,
   output sida_pkg::conv_stat_type   stat
);
   import sida_pkg::*;

   localparam int ND = digit_count(VALUE_WIDTH);
   localparam int BCD_W = ND * DIGIT_W;
   localparam int CNT_W = $clog2(VALUE_WIDTH);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;

   // shift-add-3 unit: correct every digit, then shift one binary bit in
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
         end else begin
            bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.start) begin
         bin_in  = mag;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end else if (ctl.pop) begin
         // readout: next digit moves to the top
         bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign stat.done      = ~busy_ff;
   assign stat.top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sida_pkg::*;

   // Value width of the block under test; the predictor follows it.
   localparam int VW = VALUE_WIDTH_DEF;

   // Cycles with no transfer on either channel before the run is called hung.
   // The long receiver hold-off (HOLD_CYCLES) plus a full conversion and a
   // sender gap is the worst honest stretch; this is several times that.
   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AFTER  = 40;   // item count at which the hold-off starts
   localparam int N_RANDOM    = 290;
   localparam int DRAIN_CYCLES = 120; // extra wait after the last owed character

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_rec_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [VW-1:0] req_value = '0;
   logic [7:0]           req_terminator = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_char_out;
   logic                 rsp_last;

   // Characters still owed by the block, oldest first.
   char_rec_type pending_chars[$];

   // Directed stimulus table. An empty text means "ask the predictor".
   logic [VW-1:0] dir_value[$];
   logic [7:0]    dir_term[$];
   string         dir_text[$];

   int err_count   = 0;
   int item_count  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;

   signed_int_to_decimal_ascii_unit #(
      .VALUE_WIDTH(VW)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .req_terminator(req_terminator),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last      (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
      err_count++;
   endtask

   // Append one character to the owed list.
   task automatic owe_char(input char_rec_type rec);
      pending_chars = {pending_chars, rec};
   endtask

   // Decimal expansion of one value: optional '-', digits MSB first with no
   // leading zeros, then the terminator flagged as last. The most negative
   // value negates to itself, which as an unsigned magnitude is exactly right.
   task automatic expand_decimal(input logic [VW-1:0] word, input logic [7:0] term);
      logic          neg;
      logic [VW-1:0] mag;
      logic [3:0]    digs[0:23];
      int            n;
      char_rec_type  rec;
      neg = word[VW-1];
      mag = neg ? ('0 - word) : word;
      n = 0;
      do begin
         digs[n] = 4'(mag % 10);
         n++;
         mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
         rec.ch = CH_MINUS;
         rec.last = 1'b0;
         owe_char(rec);
      end
      while (n > 0) begin
         n--;
         rec.ch = CH_ZERO + CHAR_W'(digs[n]);
         rec.last = 1'b0;
         owe_char(rec);
      end
      rec.ch = term;
      rec.last = 1'b1;
      owe_char(rec);
   endtask

   task automatic add_row(input logic [VW-1:0] word, input logic [7:0] term,
                          input string text);
      dir_value = {dir_value, word};
      dir_term  = {dir_term, term};
      dir_text  = {dir_text, text};
   endtask

   // Random value shaped to hit every digit count, the powers of ten and the
   // edges of the signed range, with plain random words for bit coverage.
   function automatic logic [VW-1:0] pick_value();
      logic [63:0] word;
      logic [63:0] p10;
      int          n;
      word = 64'd0;
      case ($urandom_range(0, 3))
         0: begin
            word = {$urandom, $urandom};
         end
         1: begin
            n = $urandom_range(1, 19);
            for (int k = 0; k < n; k++) begin
               word = word * 10 + 64'($urandom_range(0, 9));
            end
            if ($urandom_range(0, 1) == 1) word = 64'd0 - word;
         end
         2: begin
            p10 = 64'd1;
            n = $urandom_range(0, 19);
            for (int k = 0; k < n; k++) p10 = p10 * 10;
            word = p10 + 64'($urandom_range(0, 2)) - 64'd1;
            if ($urandom_range(0, 1) == 1) word = 64'd0 - word;
         end
         default: begin
            case ($urandom_range(0, 2))
               0: word = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
               1: word = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
               default: word = 64'($urandom_range(0, 6)) - 64'd3;
            endcase
         end
      endcase
      return word[VW-1:0];
   endfunction

   // Offer one value and hold it until the block takes it. Called right after
   // a rising edge. Bursts of back-to-back transfers alternate with gaps.
   task automatic offer_value(input logic [VW-1:0] word, input logic [7:0] term);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            req_value <= VW'({$urandom, $urandom});   // idle payload is don't-care
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      req_valid      <= 1'b1;
      req_value      <= word;
      req_terminator <= term;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      item_count++;
   endtask

   // Sender: directed table first, then the random part, then drain.
   initial begin : req_side
      char_rec_type rec;
      string        text;

      add_row(64'd0,                      8'h20, "0");
      add_row(64'd1,                      8'h0A, "1");
      add_row(-64'sd1,                    8'h20, "-1");
      add_row(64'h7FFF_FFFF_FFFF_FFFF,    8'h00, "9223372036854775807");
      add_row(64'h8000_0000_0000_0000,    8'hFF, "-9223372036854775808");
      add_row(64'h8000_0000_0000_0001,    8'h2C, "-9223372036854775807");
      add_row(64'd9,                      CH_MINUS, "9");  // terminator looks like '-'
      add_row(64'd10,                     CH_ZERO, "10");  // terminator looks like '0'
      add_row(-64'sd10,                   8'h20, "-10");
      add_row(64'd1000000000000000000,    8'h0A, "1000000000000000000");
      add_row(64'd99,                     8'h20, "");
      add_row(64'd100,                    8'h20, "");
      add_row(-64'sd999999999999999999,   8'h0D, "");
      add_row(-64'sd1000000000000000000,  8'h0A, "");
      add_row(64'h7FFF_FFFF_FFFF_FFFE,    8'h01, "");
      add_row(64'hAAAA_AAAA_AAAA_AAAA,    8'hAA, "");
      add_row(64'h5555_5555_5555_5555,    8'h55, "");
      add_row(64'd123456789,              8'h7F, "");
      add_row(-64'sd5,                    8'h09, "");
      add_row(64'd4294967296,             8'h80, "");
      add_row(64'hFFFF_FFFF_0000_0000,    8'hFE, "");

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < dir_value.size(); i++) begin
         offer_value(dir_value[i], dir_term[i]);
         text = dir_text[i];
         if (text.len() == 0) begin
            expand_decimal(dir_value[i], dir_term[i]);
         end else begin
            for (int k = 0; k < text.len(); k++) begin
               rec.ch = text[k];
               rec.last = 1'b0;
               owe_char(rec);
            end
            rec.ch = dir_term[i];
            rec.last = 1'b1;
            owe_char(rec);
         end
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         logic [VW-1:0] word;
         logic [7:0]    term;
         word = pick_value();
         term = 8'($urandom_range(0, 255));
         offer_value(word, term);
         expand_decimal(word, term);
      end
      req_valid <= 1'b0;

      // Wait for every owed character; the watchdog covers a hang here.
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Receiver: random stall phases, plus one long hold-off while the sender
   // keeps offering, so the block backs up and raises req_stall.
   initial begin : rsp_side
      int  phase_left;
      int  phase_mode;
      bit  hold_done;
      phase_left = 0;
      phase_mode = 0;
      hold_done  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && item_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            phase_left = 0;
         end else begin
            if (phase_left == 0) begin
               phase_mode = $urandom_range(0, 3);
               phase_left = $urandom_range(5, 60);
            end
            phase_left--;
            case (phase_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
         @(posedge clock);
      end
   end

   // Result check against the oldest owed character, and the hang watchdog.
   always @(posedge clock) begin : rsp_check
      char_rec_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_chars.size() == 0) begin
               report_mismatch("unrequested char", int'(rsp_char_out), 0);
            end else begin
               want = pending_chars.pop_front();
               if (rsp_char_out !== want.ch) begin
                  report_mismatch("char_out", int'(rsp_char_out), int'(want.ch));
               end
               if (rsp_last !== want.last) begin
                  report_mismatch("last", int'(rsp_last), int'(want.last));
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

endmodule

// File: signed_int_to_decimal_ascii_unit.f
src/sida_pkg.sv
src/sida_conv.sv
src/signed_int_to_decimal_ascii_unit.sv
tb/tb_top.sv
